@@ rtl/core/mlqs_pkg.sv @@
// Shared types and constants for the multilevel queue thread scheduler.
// Used by mlqs_entry_ram and multilevel_queue_thread_scheduler.
package mlqs_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_PICK    = 2'd1;
  localparam logic [1:0] MODE_AGING   = 2'd2;
  localparam logic [1:0] MODE_NOP     = 2'd3;

  localparam logic [1:0] LVL_HIGH = 2'd0;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LOW  = 2'd2;

  localparam logic [4:0] ADDR_MIDDLE_FLOOR  = 5'd0;
  localparam logic [4:0] ADDR_HIGH_FLOOR    = 5'd4;
  localparam logic [4:0] ADDR_PRIO_LIMIT    = 5'd8;
  localparam logic [4:0] ADDR_AGE_THRESHOLD = 5'd12;
  localparam logic [4:0] ADDR_AGING_STEP    = 5'd16;

  localparam logic [7:0]  RST_MIDDLE_FLOOR  = 8'd50;
  localparam logic [7:0]  RST_HIGH_FLOOR    = 8'd100;
  localparam logic [7:0]  RST_PRIO_LIMIT    = 8'd150;
  localparam logic [15:0] RST_AGE_THRESHOLD = 16'd1500;
  localparam logic [7:0]  RST_AGING_STEP    = 8'd10;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [31:0] stamp;
    logic [15:0] arrival;
  } entry_t;

  function automatic logic [1:0] level_of(input logic [7:0] p,
                                          input logic [7:0] high_floor,
                                          input logic [7:0] mid_floor);
    logic [1:0] lvl;
    if (p >= high_floor) begin
      lvl = LVL_HIGH;
    end else if (p >= mid_floor) begin
      lvl = LVL_MID;
    end else begin
      lvl = LVL_LOW;
    end
    return lvl;
  endfunction

endpackage

@@ rtl/core/mlqs_entry_ram.sv @@
// Entry table storage: one synchronous memory holding id, priority, burst,
// aging stamp and arrival stamp per slot. Depends on mlqs_pkg.
module mlqs_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  mlqs_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output mlqs_pkg::entry_t rd_data
);

  mlqs_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/multilevel_queue_thread_scheduler.sv @@
// Multilevel queue thread scheduler: a ready table in one synchronous memory.
// Every transaction (enqueue, pick, aging pass) scans all TABLE_ENTRIES slots
// through the memory read port, one slot a cycle; the result waits in ST_FINISH
// until the output is free, and the next transaction is taken back in ST_IDLE.
// Reset (rst, synchronous) empties the table at once through per-slot valid
// flip-flops and restores the register defaults; no clearing pass is needed.
module multilevel_queue_thread_scheduler #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // thread_id[7:0], thread_priority[15:8], burst_estimate[31:16], now_tick[63:32],
  // running_active[64], running_id[72:65], running_priority[80:73],
  // running_remaining[96:81], zero fill[103:97]
  input  logic [103:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]   s_tuser,
  // Output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // grant_valid[0], grant_id[8:1], grant_level[10:9], table_full[11],
  // aged_count[16:12], zero fill[23:17]
  output logic [23:0]  m_tdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // Configuration registers
  logic [7:0]  middle_band_floor, high_band_floor, priority_limit, aging_step;
  logic [15:0] age_threshold;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      middle_band_floor <= mlqs_pkg::RST_MIDDLE_FLOOR;
      high_band_floor   <= mlqs_pkg::RST_HIGH_FLOOR;
      priority_limit    <= mlqs_pkg::RST_PRIO_LIMIT;
      age_threshold     <= mlqs_pkg::RST_AGE_THRESHOLD;
      aging_step        <= mlqs_pkg::RST_AGING_STEP;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        mlqs_pkg::ADDR_MIDDLE_FLOOR:  middle_band_floor <= pwdata[7:0];
        mlqs_pkg::ADDR_HIGH_FLOOR:    high_band_floor   <= pwdata[7:0];
        mlqs_pkg::ADDR_PRIO_LIMIT:    priority_limit    <= pwdata[7:0];
        mlqs_pkg::ADDR_AGE_THRESHOLD: age_threshold     <= pwdata[15:0];
        mlqs_pkg::ADDR_AGING_STEP:    aging_step        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      mlqs_pkg::ADDR_MIDDLE_FLOOR:  prdata = {24'd0, middle_band_floor};
      mlqs_pkg::ADDR_HIGH_FLOOR:    prdata = {24'd0, high_band_floor};
      mlqs_pkg::ADDR_PRIO_LIMIT:    prdata = {24'd0, priority_limit};
      mlqs_pkg::ADDR_AGE_THRESHOLD: prdata = {16'd0, age_threshold};
      mlqs_pkg::ADDR_AGING_STEP:    prdata = {24'd0, aging_step};
      default:                      prdata = 32'd0;
    endcase
  end

  logic [7:0] prio_cap;
  assign prio_cap = (priority_limit == 8'd0) ? 8'd0 : priority_limit - 8'd1;

  // Latched input item
  logic [1:0]  op;
  logic [7:0]  t_id, t_prio, r_id, r_prio;
  logic [15:0] t_burst, r_rem;
  logic [31:0] now;
  logic        r_active;

  mlqs_pkg::state_t state, state_next;
  logic [CW-1:0] cnt;
  logic          pv;
  logic [IW-1:0] pidx;
  logic          last;
  logic          accept, finish_go;

  assign s_tready  = (state == mlqs_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign last      = pv && (pidx == IW'(TABLE_ENTRIES - 1));
  assign finish_go = (state == mlqs_pkg::ST_FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlqs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mlqs_pkg::ST_IDLE:   if (accept) state_next = mlqs_pkg::ST_SCAN;
      mlqs_pkg::ST_SCAN:   if (last) state_next = mlqs_pkg::ST_FINISH;
      mlqs_pkg::ST_FINISH: if (finish_go) state_next = mlqs_pkg::ST_IDLE;
      default:             state_next = mlqs_pkg::ST_IDLE;
    endcase
  end

  // Memory
  logic              rd_en, wr_en;
  logic [IW-1:0]     rd_addr;
  mlqs_pkg::entry_t  rd_data, wr_data;

  assign rd_en   = (state == mlqs_pkg::ST_SCAN) && (cnt < CW'(TABLE_ENTRIES));
  assign rd_addr = cnt[IW-1:0];

  // Reads run one slot ahead of the write-back, so a slot is never read
  // and written in overlapping cycles.
  mlqs_entry_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pidx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [TABLE_ENTRIES-1:0] valid;
  logic [15:0] arrival_counter;
  logic        found;
  logic [4:0]  aged;

  // Best candidate per level
  logic          b0_ok, b1_ok, b2_ok;
  logic [IW-1:0] b0_slot, b1_slot, b2_slot;
  logic [7:0]    b0_id, b1_id, b2_id, b1_prio;
  logic [15:0]   b0_burst, b0_age, b1_age, b2_age;

  // Processing of the slot whose read data is present
  logic        ev;
  logic [1:0]  e_lvl;
  logic [15:0] e_age;
  logic        enq_hit, age_hit, age_relevel;
  logic [8:0]  age_sum;
  logic [7:0]  age_newp;
  logic        w0, w1, w2;

  always_comb begin
    ev      = pv && valid[pidx];
    e_lvl   = mlqs_pkg::level_of(rd_data.prio, high_band_floor, middle_band_floor);
    e_age   = arrival_counter - rd_data.arrival;
    enq_hit = pv && !valid[pidx] && !found && (op == mlqs_pkg::MODE_ENQUEUE);
    age_hit = ev && (op == mlqs_pkg::MODE_AGING) &&
              ((now - rd_data.stamp) >= {16'd0, age_threshold});
    age_sum = {1'b0, rd_data.prio} + {1'b0, aging_step};
    age_newp = (age_sum > {1'b0, prio_cap}) ? prio_cap : age_sum[7:0];
    age_relevel = e_lvl !=
                  mlqs_pkg::level_of(age_newp, high_band_floor, middle_band_floor);

    w0 = ev && (op == mlqs_pkg::MODE_PICK) && (e_lvl == mlqs_pkg::LVL_HIGH) &&
         (!b0_ok || (rd_data.burst < b0_burst) ||
          (rd_data.burst == b0_burst && rd_data.id < b0_id) ||
          (rd_data.burst == b0_burst && rd_data.id == b0_id && e_age > b0_age));
    w1 = ev && (op == mlqs_pkg::MODE_PICK) && (e_lvl == mlqs_pkg::LVL_MID) &&
         (!b1_ok || (rd_data.prio > b1_prio) ||
          (rd_data.prio == b1_prio && rd_data.id < b1_id) ||
          (rd_data.prio == b1_prio && rd_data.id == b1_id && e_age > b1_age));
    w2 = ev && (op == mlqs_pkg::MODE_PICK) && (e_lvl == mlqs_pkg::LVL_LOW) &&
         (!b2_ok || e_age > b2_age);

    wr_en   = enq_hit || age_hit;
    wr_data = rd_data;
    if (enq_hit) begin
      wr_data.id      = t_id;
      wr_data.prio    = (t_prio > prio_cap) ? prio_cap : t_prio;
      wr_data.burst   = t_burst;
      wr_data.stamp   = now;
      wr_data.arrival = arrival_counter;
    end else begin
      wr_data.prio  = age_newp;
      wr_data.stamp = now;
      if (age_relevel) begin
        wr_data.arrival = arrival_counter;
      end
    end
  end

  // Pick decision
  logic [1:0] r_lvl;
  logic       blk0, take0, lower_ok, take1, take2, g_valid;
  logic [7:0] g_id;
  logic [1:0] g_lvl;
  logic [IW-1:0] g_slot;

  always_comb begin
    r_lvl    = mlqs_pkg::level_of(r_prio, high_band_floor, middle_band_floor);
    blk0     = r_active && (r_lvl == mlqs_pkg::LVL_HIGH) &&
               ((r_rem < b0_burst) || (r_rem == b0_burst && r_id < b0_id));
    take0    = b0_ok && !blk0;
    lower_ok = !(r_active && r_lvl != mlqs_pkg::LVL_LOW);
    take1    = !take0 && lower_ok && b1_ok;
    take2    = !take0 && lower_ok && !b1_ok && b2_ok;
    g_valid  = (op == mlqs_pkg::MODE_PICK) && (take0 || take1 || take2);
    g_id     = 8'd0;
    g_lvl    = mlqs_pkg::LVL_HIGH;
    g_slot   = b0_slot;
    priority if (take0) begin
      g_id = b0_id;
    end else if (take1) begin
      g_id = b1_id; g_lvl = mlqs_pkg::LVL_MID; g_slot = b1_slot;
    end else if (take2) begin
      g_id = b2_id; g_lvl = mlqs_pkg::LVL_LOW; g_slot = b2_slot;
    end
    if (!g_valid) begin
      g_id  = 8'd0;
      g_lvl = mlqs_pkg::LVL_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= s_tuser;
      t_id     <= s_tdata[7:0];
      t_prio   <= s_tdata[15:8];
      t_burst  <= s_tdata[31:16];
      now      <= s_tdata[63:32];
      r_active <= s_tdata[64];
      r_id     <= s_tdata[72:65];
      r_prio   <= s_tdata[80:73];
      r_rem    <= s_tdata[96:81];
    end
    if (w0) begin
      b0_slot <= pidx; b0_id <= rd_data.id; b0_burst <= rd_data.burst; b0_age <= e_age;
    end
    if (w1) begin
      b1_slot <= pidx; b1_id <= rd_data.id; b1_prio <= rd_data.prio; b1_age <= e_age;
    end
    if (w2) begin
      b2_slot <= pidx; b2_id <= rd_data.id; b2_age <= e_age;
    end
    if (finish_go) begin
      m_tdata <= {7'd0,
                  (op == mlqs_pkg::MODE_AGING) ? aged : 5'd0,
                  (op == mlqs_pkg::MODE_ENQUEUE) && !found,
                  g_lvl, g_id, g_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      arrival_counter <= 16'd0;
      cnt             <= '0;
      pv              <= 1'b0;
      pidx            <= '0;
      found           <= 1'b0;
      aged            <= 5'd0;
      b0_ok           <= 1'b0;
      b1_ok           <= 1'b0;
      b2_ok           <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (accept) begin
        cnt   <= '0;
        pv    <= 1'b0;
        found <= 1'b0;
        aged  <= 5'd0;
        b0_ok <= 1'b0;
        b1_ok <= 1'b0;
        b2_ok <= 1'b0;
      end else if (state == mlqs_pkg::ST_SCAN) begin
        pv <= rd_en;
        if (rd_en) begin
          pidx <= rd_addr;
          cnt  <= cnt + CW'(1);
        end
      end
      if (enq_hit) begin
        valid[pidx]     <= 1'b1;
        found           <= 1'b1;
        arrival_counter <= arrival_counter + 16'd1;
      end
      if (age_hit) begin
        if (age_relevel) begin
          arrival_counter <= arrival_counter + 16'd1;
        end
        if (aged != 5'd31) begin
          aged <= aged + 5'd1;
        end
      end
      if (w0) b0_ok <= 1'b1;
      if (w1) b1_ok <= 1'b1;
      if (w2) b2_ok <= 1'b1;
      if (finish_go) begin
        m_tvalid <= 1'b1;
        if (g_valid) begin
          valid[g_slot] <= 1'b0;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
